>>> rtl/fkm_pkg.sv
// Shared constants, state encoding and control structs for the frequent k-mer block.
package fkm_pkg;

  localparam int MAX_LEN_DEF     = 1024;
  localparam int K_MAX_DEF       = 12;
  localparam int MAX_RESULTS_DEF = 64;

  localparam int PATTERN_W = 24;
  localparam int OCC_W     = 12;
  localparam int KLEN_W    = 4;
  localparam int DIST_W    = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 4;

  localparam logic [OCC_W-1:0] CNT_SAT = 12'd4095;

  localparam logic [KLEN_W-1:0] KLEN_RESET = 4'd9;
  localparam logic [DIST_W-1:0] DIST_RESET = 2'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KMER_LENGTH    = 1'b0,
    REG_MAX_MISMATCHES = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_START,
    ST_SCAN_INIT,
    ST_SCAN,
    ST_EVAL,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic clear_len;
    logic init;
    logic scan_start;
    logic scan_run;
    logic update_best;
    logic to_pass2;
    logic next_p;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic enough;
    logic scan_done;
    logic last_p;
    logic pass2;
    logic hit;
    logic out_last;
  } status_t;

endpackage

>>> rtl/frequent_kmer_mismatch_revcomp.sv
// Top level: most frequent k-mers with mismatches and reverse complements.
//
// Input channel (in_valid/in_ready) takes one base per word, one word per cycle,
// while the block is loading. The word with final_base set starts the search.
// For every pattern code 0 .. 4^k-1 the block walks the stored sequence once
// through the single-port sequence RAM, counting windows within the mismatch
// limit of the pattern and of its reverse complement. A first walk finds the
// best score, a second walk emits the tied patterns in ascending order.
// in_ready stays low for the whole search.
// Output channel (out_valid/out_ready) holds each result word in a register
// until it is taken; a stalled receiver simply pauses the walk. After the word
// marked last_result (or at once if the sequence is shorter than k) the block
// returns to loading with an empty sequence. Configuration registers must only
// be written while the block is loading. Reset empties the sequence, restores
// k = 9 and d = 1.
module frequent_kmer_mismatch_revcomp #(
  parameter int MAX_LEN     = fkm_pkg::MAX_LEN_DEF,
  parameter int K_MAX       = fkm_pkg::K_MAX_DEF,
  parameter int MAX_RESULTS = fkm_pkg::MAX_RESULTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       base,
  input  logic                             final_base,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [fkm_pkg::PATTERN_W-1:0]    pattern,
  output logic [fkm_pkg::OCC_W-1:0]        occurrences,
  output logic                             truncated,
  output logic                             last_result,
  input  logic                             cfg_write,
  input  logic [fkm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fkm_pkg::CFG_W-1:0]        cfg_data
);

  fkm_pkg::cmd_t    cmd;
  fkm_pkg::status_t st;

  logic [fkm_pkg::KLEN_W-1:0] kmer_length;
  logic [fkm_pkg::DIST_W-1:0] max_mismatches;

  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_length    <= fkm_pkg::KLEN_RESET;
      max_mismatches <= fkm_pkg::DIST_RESET;
    end else if (cfg_write) begin
      case (fkm_pkg::cfg_reg_t'(cfg_index))
        fkm_pkg::REG_KMER_LENGTH:    kmer_length    <= cfg_data;
        fkm_pkg::REG_MAX_MISMATCHES: max_mismatches <= cfg_data[fkm_pkg::DIST_W-1:0];
        default: ;
      endcase
    end
  end

  fkm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .final_base (final_base),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .st         (st),
    .cmd        (cmd)
  );

  fkm_datapath #(
    .MAX_LEN     (MAX_LEN),
    .K_MAX       (K_MAX),
    .MAX_RESULTS (MAX_RESULTS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .st             (st),
    .base           (base),
    .kmer_length    (kmer_length),
    .max_mismatches (max_mismatches),
    .pattern        (pattern),
    .occurrences    (occurrences),
    .truncated      (truncated),
    .last_result    (last_result)
  );

`ifndef SYNTHESIS
  a_busy_excl: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input accepted while a result word is pending");
  a_occ_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> occurrences != '0)
    else $error("result word with zero occurrences");
  a_last_returns: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_result) |=> in_ready)
    else $error("block did not return to loading after the last result");
`endif

endmodule

>>> rtl/fkm_ram.sv
// Generic single-port RAM with registered read data.
module fkm_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> rtl/fkm_ctrl.sv
// Controller state machine sequencing load, scan passes and result delivery.
module fkm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              final_base,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  fkm_pkg::status_t  st,
  output fkm_pkg::cmd_t     cmd
);

  fkm_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fkm_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      fkm_pkg::ST_LOAD: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        if (in_valid && final_base) begin
          state_next = fkm_pkg::ST_START;
        end
      end
      fkm_pkg::ST_START: begin
        if (!st.enough) begin
          cmd.clear_len = 1'b1;
          state_next    = fkm_pkg::ST_LOAD;
        end else begin
          cmd.init   = 1'b1;
          state_next = fkm_pkg::ST_SCAN_INIT;
        end
      end
      fkm_pkg::ST_SCAN_INIT: begin
        cmd.scan_start = 1'b1;
        state_next     = fkm_pkg::ST_SCAN;
      end
      fkm_pkg::ST_SCAN: begin
        cmd.scan_run = 1'b1;
        if (st.scan_done) begin
          state_next = fkm_pkg::ST_EVAL;
        end
      end
      fkm_pkg::ST_EVAL: begin
        if (!st.pass2) begin
          cmd.update_best = 1'b1;
          if (st.last_p) begin
            cmd.to_pass2 = 1'b1;
          end else begin
            cmd.next_p = 1'b1;
          end
          state_next = fkm_pkg::ST_SCAN_INIT;
        end else if (st.hit) begin
          cmd.emit   = 1'b1;
          state_next = fkm_pkg::ST_EMIT;
        end else if (st.last_p) begin
          cmd.clear_len = 1'b1;
          state_next    = fkm_pkg::ST_LOAD;
        end else begin
          cmd.next_p = 1'b1;
          state_next = fkm_pkg::ST_SCAN_INIT;
        end
      end
      fkm_pkg::ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (st.out_last || st.last_p) begin
            cmd.clear_len = 1'b1;
            state_next    = fkm_pkg::ST_LOAD;
          end else begin
            cmd.next_p = 1'b1;
            state_next = fkm_pkg::ST_SCAN_INIT;
          end
        end
      end
      default: begin
        state_next = fkm_pkg::ST_LOAD;
      end
    endcase
  end

endmodule

>>> rtl/fkm_datapath.sv
// Datapath: sequence store, window scan, mismatch counting, scoring and result registers.
module fkm_datapath #(
  parameter int MAX_LEN     = fkm_pkg::MAX_LEN_DEF,
  parameter int K_MAX       = fkm_pkg::K_MAX_DEF,
  parameter int MAX_RESULTS = fkm_pkg::MAX_RESULTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  fkm_pkg::cmd_t                    cmd,
  output fkm_pkg::status_t                 st,
  input  logic [1:0]                       base,
  input  logic [fkm_pkg::KLEN_W-1:0]       kmer_length,
  input  logic [fkm_pkg::DIST_W-1:0]       max_mismatches,
  output logic [fkm_pkg::PATTERN_W-1:0]    pattern,
  output logic [fkm_pkg::OCC_W-1:0]        occurrences,
  output logic                             truncated,
  output logic                             last_result
);

  localparam int AW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int PW = 2 * K_MAX;
  localparam int KW = $clog2(K_MAX + 1);
  localparam int TW = $clog2(MAX_RESULTS + 2);
  localparam int SW = fkm_pkg::OCC_W + 1;

  logic [CW-1:0] len;
  logic [CW-1:0] addr;
  logic [CW-1:0] rd_idx;
  logic          rd_valid;
  logic          issue;
  logic [PW-1:0] p;
  logic [PW-1:0] win;
  logic [PW-1:0] win_new;
  logic [PW-1:0] mask;
  logic [PW-1:0] rc_full;
  logic [PW-1:0] rc;
  logic          pass2;
  logic [CW-1:0] cnt_f;
  logic [CW-1:0] cnt_r;
  logic [fkm_pkg::OCC_W-1:0] best;
  logic [TW-1:0] ties;
  logic [TW-1:0] nemit;
  logic [TW-1:0] limit;
  logic [KW-1:0] k_eff;
  logic [KW-1:0] dist_f;
  logic [KW-1:0] dist_r;
  logic [SW-1:0] f_sat;
  logic [SW-1:0] r_sat;
  logic [SW-1:0] sum;
  logic [fkm_pkg::OCC_W-1:0] score;
  logic          cand;
  logic          win_ok;
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [1:0]    ram_rdata;

  // A length of zero acts as one; anything above the maximum is clamped.
  always_comb begin
    if (kmer_length == '0) begin
      k_eff = KW'(1);
    end else if (32'(kmer_length) > K_MAX) begin
      k_eff = KW'(K_MAX);
    end else begin
      k_eff = KW'(kmer_length);
    end
  end

  assign mask = ~({PW{1'b1}} << (2 * k_eff));

  assign ram_we   = cmd.load && (32'(len) < MAX_LEN);
  assign ram_addr = cmd.load ? len[AW-1:0] : addr[AW-1:0];
  assign issue    = cmd.scan_run && (addr < len);

  fkm_ram #(
    .WIDTH (2),
    .DEPTH (MAX_LEN)
  ) u_seq_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (base),
    .rdata (ram_rdata)
  );

  // Reverse complement: complement every base, reverse the full word, then drop unused bases.
  always_comb begin
    for (int j = 0; j < K_MAX; j++) begin
      rc_full[2*j +: 2] = ~p[2*(K_MAX-1-j) +: 2];
    end
    rc = rc_full >> (2 * (K_MAX - k_eff));
  end

  assign win_new = ((win << 2) | PW'(ram_rdata)) & mask;

  always_comb begin
    dist_f = '0;
    dist_r = '0;
    for (int j = 0; j < K_MAX; j++) begin
      dist_f = dist_f + KW'((win_new[2*j +: 2] ^ p[2*j +: 2]) != 2'd0);
      dist_r = dist_r + KW'((win_new[2*j +: 2] ^ rc[2*j +: 2]) != 2'd0);
    end
  end

  assign win_ok = rd_valid && (32'(rd_idx) + 32'd1 >= 32'(k_eff));

  // Each count saturates before the two are added, and the sum saturates again.
  always_comb begin
    f_sat = (32'(cnt_f) > 32'(fkm_pkg::CNT_SAT)) ? SW'(fkm_pkg::CNT_SAT) : SW'(cnt_f);
    r_sat = (32'(cnt_r) > 32'(fkm_pkg::CNT_SAT)) ? SW'(fkm_pkg::CNT_SAT) : SW'(cnt_r);
    sum   = f_sat + r_sat;
    score = (sum > SW'(fkm_pkg::CNT_SAT)) ? fkm_pkg::CNT_SAT : sum[fkm_pkg::OCC_W-1:0];
  end

  assign cand  = (cnt_f != '0);
  assign limit = (32'(ties) > MAX_RESULTS) ? TW'(MAX_RESULTS) : ties;

  always_comb begin
    st.enough    = 32'(len) >= 32'(k_eff);
    st.scan_done = rd_valid && (rd_idx == len - CW'(1));
    st.last_p    = (p == mask);
    st.pass2     = pass2;
    st.hit       = cand && (score == best);
    st.out_last  = last_result;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len      <= '0;
      rd_valid <= 1'b0;
      pass2    <= 1'b0;
    end else begin
      if (cmd.clear_len) begin
        len <= '0;
      end else if (ram_we) begin
        len <= len + CW'(1);
      end
      rd_valid <= issue;
      if (cmd.init) begin
        pass2 <= 1'b0;
      end else if (cmd.to_pass2) begin
        pass2 <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      p     <= '0;
      best  <= '0;
      ties  <= '0;
      nemit <= '0;
    end
    if (cmd.scan_start) begin
      addr  <= '0;
      win   <= '0;
      cnt_f <= '0;
      cnt_r <= '0;
    end else begin
      if (issue) begin
        addr <= addr + CW'(1);
      end
      rd_idx <= addr;
      if (rd_valid) begin
        win <= win_new;
      end
      if (win_ok && (32'(dist_f) <= 32'(max_mismatches))) begin
        cnt_f <= cnt_f + CW'(1);
      end
      if (win_ok && (32'(dist_r) <= 32'(max_mismatches))) begin
        cnt_r <= cnt_r + CW'(1);
      end
    end
    if (cmd.update_best && cand) begin
      if (score > best) begin
        best <= score;
        ties <= TW'(1);
      end else if (score == best && 32'(ties) <= MAX_RESULTS) begin
        ties <= ties + TW'(1);
      end
    end
    if (cmd.to_pass2) begin
      p <= '0;
    end else if (cmd.next_p) begin
      p <= p + PW'(1);
    end
    if (cmd.emit) begin
      pattern     <= fkm_pkg::PATTERN_W'(p);
      occurrences <= score;
      truncated   <= (32'(ties) > MAX_RESULTS);
      last_result <= (nemit + TW'(1) == limit);
      nemit       <= nemit + TW'(1);
    end
  end

endmodule

>>> test/tb_frequent_kmer_mismatch_revcomp.sv
// Testbench for the frequent k-mer block: directed and random sequences checked against a predictor.
module tb_frequent_kmer_mismatch_revcomp;

  localparam int SEQ_CAP   = 1024;
  localparam int K_CAP     = 12;
  localparam int LIST_CAP  = 64;
  localparam int CYCLE_CAP = 3000000;

  typedef struct {
    logic [fkm_pkg::PATTERN_W-1:0] pat;
    logic [fkm_pkg::OCC_W-1:0]     occ;
    logic                          trunc;
    logic                          last;
  } kmer_hit_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] base = 2'd0;
  logic final_base = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [fkm_pkg::PATTERN_W-1:0] pattern;
  logic [fkm_pkg::OCC_W-1:0] occurrences;
  logic truncated;
  logic last_result;
  logic cfg_write = 1'b0;
  logic [fkm_pkg::CFG_IDX_W-1:0] cfg_index = fkm_pkg::REG_KMER_LENGTH;
  logic [fkm_pkg::CFG_W-1:0] cfg_data = '0;

  frequent_kmer_mismatch_revcomp dut (.*);

  always #6 clk = ~clk;

  // Predictor state.
  logic [1:0] held_bases [SEQ_CAP];
  int held_len;
  logic [fkm_pkg::KLEN_W-1:0] kmer_len_reg;
  logic [fkm_pkg::DIST_W-1:0] mismatch_reg;
  kmer_hit_t answer_q [$];

  int errors;
  int bases_sent;
  int searches;
  int words_checked;
  int cycle_count;
  bit steady;
  int out_hold;

  task automatic report(input string what);
    errors++;
    $display("MISMATCH t=%0t: %s", $time, what);
  endtask

  function automatic int hamming(input int a, input int b, input int k);
    int n;
    n = 0;
    for (int i = 0; i < k; i++)
      if (((a >> (2 * i)) & 3) != ((b >> (2 * i)) & 3)) n++;
    return n;
  endfunction

  function automatic int revcomp(input int code, input int k);
    int r;
    r = 0;
    for (int i = 0; i < k; i++) begin
      r = (r << 2) | (3 - (code & 3));
      code = code >> 2;
    end
    return r;
  endfunction

  // Scores every candidate and queues up to LIST_CAP of the tied best patterns in code order.
  task automatic predict_answer();
    int k;
    int npat;
    int code;
    int best;
    int ties;
    int n;
    int s;
    int hits [];
    kmer_hit_t item;
    k = (kmer_len_reg == 0) ? 1 : (kmer_len_reg > K_CAP) ? K_CAP : int'(kmer_len_reg);
    if (held_len < k) return;
    npat = 1 << (2 * k);
    hits = new[npat];
    foreach (hits[p]) hits[p] = 0;
    code = 0;
    for (int i = 0; i < held_len; i++) begin
      code = ((code << 2) | held_bases[i]) & (npat - 1);
      if (i + 1 >= k)
        for (int p = 0; p < npat; p++)
          if (hamming(p, code, k) <= mismatch_reg) hits[p]++;
    end
    best = 0;
    for (int p = 0; p < npat; p++)
      if (hits[p] != 0) begin
        s = hits[p] + hits[revcomp(p, k)];
        if (s > 4095) s = 4095;
        if (s > best) best = s;
      end
    ties = 0;
    n = 0;
    for (int p = 0; p < npat; p++)
      if (hits[p] != 0) begin
        s = hits[p] + hits[revcomp(p, k)];
        if (s > 4095) s = 4095;
        if (s == best) begin
          ties++;
          if (n < LIST_CAP) begin
            item.pat = fkm_pkg::PATTERN_W'(p);
            item.occ = fkm_pkg::OCC_W'(best);
            item.trunc = 1'b0;
            item.last = 1'b0;
            answer_q.insert(answer_q.size(), item);
            n++;
          end
        end
      end
    for (int j = answer_q.size() - n; j < answer_q.size(); j++)
      answer_q[j].trunc = (ties > LIST_CAP);
    if (n > 0) answer_q[answer_q.size() - 1].last = 1'b1;
  endtask

  // Leaves valid high after the word is taken; the next word or an idle gap replaces it.
  task automatic send_base(input logic [1:0] b, input logic fin);
    if (!steady && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_valid <= 1'b1;
    base <= b;
    final_base <= fin;
    do @(posedge clk); while (!in_ready);
    bases_sent++;
    if (held_len < SEQ_CAP) held_bases[held_len] = b;
    if (held_len < SEQ_CAP) held_len++;
    if (fin) begin
      searches++;
      predict_answer();
      held_len = 0;
    end
    @(negedge clk);
  endtask

  // Waits until every queued answer word has arrived and the block has settled.
  task automatic drain();
    in_valid <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input fkm_pkg::cfg_reg_t idx,
                           input logic [fkm_pkg::CFG_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == fkm_pkg::REG_KMER_LENGTH) kmer_len_reg = val;
    else mismatch_reg = val[fkm_pkg::DIST_W-1:0];
  endtask

  task automatic send_seq(input int len, input int motif);
    for (int i = 0; i < len; i++)
      send_base(motif < 0 ? 2'($urandom_range(0, 3)) : 2'((motif >> (2 * (i % 4))) & 3),
                i == len - 1);
    drain();
  endtask

  task automatic test_reset_values();
    // Default k is nine, so a three-base sequence must return nothing.
    send_base(2'd3, 1'b0);
    send_base(2'd0, 1'b0);
    send_base(2'd2, 1'b1);
    drain();
  endtask

  task automatic test_extremes();
    write_reg(fkm_pkg::REG_KMER_LENGTH, 4'd12);
    write_reg(fkm_pkg::REG_MAX_MISMATCHES, 4'd0);
    send_seq(6, -1);
    write_reg(fkm_pkg::REG_KMER_LENGTH, 4'd15);
    write_reg(fkm_pkg::REG_MAX_MISMATCHES, 4'd3);
    send_seq(4, -1);
    write_reg(fkm_pkg::REG_KMER_LENGTH, 4'd0);
    write_reg(fkm_pkg::REG_MAX_MISMATCHES, 4'd0);
    send_seq(4, 8'b11100100);
    write_reg(fkm_pkg::REG_KMER_LENGTH, 4'd2);
    write_reg(fkm_pkg::REG_MAX_MISMATCHES, 4'd3);
    send_seq(2, 8'b00000111);
    // Four identical bases with a wide distance tie far more patterns than the list holds.
    write_reg(fkm_pkg::REG_KMER_LENGTH, 4'd4);
    send_seq(4, 0);
  endtask

  task automatic test_overflow();
    write_reg(fkm_pkg::REG_KMER_LENGTH, 4'd1);
    write_reg(fkm_pkg::REG_MAX_MISMATCHES, 4'd0);
    send_seq(SEQ_CAP + 6, -1);
  endtask

  task automatic test_random();
    int start;
    int len;
    start = bases_sent;
    while (bases_sent - start < 360) begin
      if (bases_sent - start > 300) steady = 1'b1;
      write_reg(fkm_pkg::REG_KMER_LENGTH,
                $urandom_range(0, 9) == 0 ? 4'd4 : 4'($urandom_range(0, 3)));
      write_reg(fkm_pkg::REG_MAX_MISMATCHES, 4'($urandom_range(0, 3)));
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 30);
      send_seq(len, $urandom_range(0, 2) == 0 ? int'($urandom_range(0, 255)) : -1);
    end
  endtask

  always @(negedge clk) begin
    if (steady) begin
      out_ready <= 1'b1;
    end else if (out_hold > 0) begin
      out_hold <= out_hold - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      out_hold <= $urandom_range(0, 12);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (answer_q.size() == 0) begin
        report($sformatf("unexpected word pattern=%h", pattern));
      end else begin
        kmer_hit_t want;
        want = answer_q.pop_front();
        words_checked++;
        if (pattern !== want.pat)
          report($sformatf("pattern %h, want %h", pattern, want.pat));
        if (occurrences !== want.occ)
          report($sformatf("occurrences %0d, want %0d", occurrences, want.occ));
        if (truncated !== want.trunc)
          report($sformatf("truncated %b, want %b", truncated, want.trunc));
        if (last_result !== want.last)
          report($sformatf("last_result %b, want %b", last_result, want.last));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    held_len = 0;
    kmer_len_reg = fkm_pkg::KLEN_RESET;
    mismatch_reg = fkm_pkg::DIST_RESET;
    errors = 0;
    bases_sent = 0;
    searches = 0;
    words_checked = 0;
    cycle_count = 0;
    steady = 1'b0;
    out_hold = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_reset_values();
    test_extremes();
    test_overflow();
    test_random();
    drain();
    if (answer_q.size() != 0) report($sformatf("%0d words never arrived", answer_q.size()));
    $display("Covered %0d bases in %0d sequences, %0d answer words compared.",
             bases_sent, searches, words_checked);
    $display("Lengths 0 to 15, distances 0 to 3, overflow and truncated lists included.");
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
